### hw/rtl/gateway_binary_frame_deframer_top_macros.svh
// assertion macros for the gateway binary frame deframer
`ifndef GATEWAY_BINARY_FRAME_DEFRAMER_TOP_MACROS_SVH
`define GATEWAY_BINARY_FRAME_DEFRAMER_TOP_MACROS_SVH

// condition that must hold at every edge outside reset
`define GBFD_AST_HOLD(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("deframer check failed");

// antecedent implies consequent at the same edge
`define GBFD_AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// antecedent implies consequent at the next edge
`define GBFD_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

### hw/rtl/gbfd_pkg.sv
// types and constants of the gateway binary frame deframer
package gbfd_pkg;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_DROP    = 2'd2
	} kind_t;

	localparam logic [1:0] REG_SYNC_VALUE   = 2'd0;
	localparam logic [1:0] REG_FLAG_MASK    = 2'd1;
	localparam logic [1:0] REG_VIDEO_MARKER = 2'd2;
	localparam logic [1:0] REG_TEXT_MARKER  = 2'd3;

	localparam logic [7:0] SYNC_RESET   = 8'hA5;
	localparam logic [7:0] FLAG_RESET   = 8'h80;
	localparam logic [7:0] VIDEO_RESET  = 8'hFE;
	localparam logic [7:0] TEXT_RESET   = 8'hFD;
	localparam logic [7:0] PF_PDU2_MIN  = 8'hF0;
	localparam logic [7:0] BROADCAST    = 8'hFF;
	localparam logic [1:0] TYPE_LONGLEN = 2'd3;

	typedef struct packed {
		kind_t       kind;
		logic [16:0] group_number;
		logic [2:0]  priority_res;
		logic [7:0]  source;
		logic [7:0]  destination;
		logic [1:0]  message_type;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
		logic        last;
	} res_t;

endpackage

### hw/rtl/gateway_binary_frame_deframer_top.sv
// Gateway binary frame deframer: takes one received byte per item and returns at most one
// result per byte (frame header, payload byte or dropped byte). A byte is decoded in the cycle
// it is accepted, against the frame phase register, and its result is registered, so the block
// sustains one byte per clock as long as in_ready stays high. Results leave
// through a two-entry output buffer, so in_ready stays high while one result waits; it falls
// only when both entries are full. The header goes out as soon as the length bytes are in.
module gateway_binary_frame_deframer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output gbfd_pkg::kind_t     kind,
	output logic [16:0]         group_number,
	output logic [2:0]          priority_res,
	output logic [7:0]          source,
	output logic [7:0]          destination,
	output logic [1:0]          message_type,
	output logic [15:0]         payload_length,
	output logic [7:0]          data_byte,
	output logic                last,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import gbfd_pkg::*;

	typedef enum logic [3:0] {
		PH_HUNT, PH_FLAG, PH_PF, PH_PS, PH_SRC, PH_LEN0, PH_LEN1, PH_DATA, PH_SKIP
	} phase_t;

	logic [7:0] sync_value_q, flag_mask_q, video_marker_q, text_marker_q;
	phase_t     phase_q, phase_d;
	logic [7:0] flag_q, pf_q, ps_q, src_q, len_low_q;
	logic [15:0] left_q, left_d;

	res_t out_q, skid_q, res_d;
	logic out_valid_q, skid_valid_q, res_vld;
	logic in_fire, out_fire;

	logic   hunt_vld;
	phase_t hunt_phase;
	logic [15:0] len_sel, left_dec;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_fire  = out_valid_q && out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q   <= SYNC_RESET;
			flag_mask_q    <= FLAG_RESET;
			video_marker_q <= VIDEO_RESET;
			text_marker_q  <= TEXT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_VALUE:   sync_value_q   <= cfg_data;
				REG_FLAG_MASK:    flag_mask_q    <= cfg_data;
				REG_VIDEO_MARKER: video_marker_q <= cfg_data;
				REG_TEXT_MARKER:  text_marker_q  <= cfg_data;
				default:          sync_value_q   <= sync_value_q;
			endcase
		end
	end

	// byte seen while hunting for a frame start
	always_comb begin
		hunt_vld   = 1'b0;
		hunt_phase = PH_HUNT;
		if (rx_byte == sync_value_q) begin
			hunt_phase = PH_FLAG;
		end else if (rx_byte == video_marker_q || rx_byte == text_marker_q || !rx_byte[7]) begin
			// a bare nul is an empty message
			hunt_phase = (rx_byte == 8'd0) ? PH_HUNT : PH_SKIP;
		end else begin
			hunt_vld = 1'b1;
		end
	end

	assign len_sel  = (phase_q == PH_LEN1) ? {rx_byte, len_low_q} : {8'd0, rx_byte};
	assign left_dec = left_q - 16'd1;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		res_vld = 1'b0;
		res_d   = '0;
		case (phase_q)
			PH_FLAG: begin
				if ((rx_byte & flag_mask_q) == 8'd0) begin
					phase_d = hunt_phase;
					res_vld = hunt_vld;
					res_d.kind      = KIND_DROP;
					res_d.data_byte = rx_byte;
				end else begin
					phase_d = PH_PF;
				end
			end
			PH_PF:  phase_d = PH_PS;
			PH_PS:  phase_d = PH_SRC;
			PH_SRC: phase_d = PH_LEN0;
			PH_LEN0, PH_LEN1: begin
				if (phase_q == PH_LEN0 && flag_q[2:1] == TYPE_LONGLEN) begin
					phase_d = PH_LEN1;
				end else begin
					res_vld = 1'b1;
					res_d.kind           = KIND_HEADER;
					res_d.group_number   = {flag_q[0], pf_q, 8'd0};
					res_d.destination    = ps_q;
					if (pf_q >= PF_PDU2_MIN) begin
						res_d.group_number[7:0] = ps_q;
						res_d.destination       = BROADCAST;
					end
					res_d.priority_res   = flag_q[6:4];
					res_d.source         = src_q;
					res_d.message_type   = flag_q[2:1];
					res_d.payload_length = len_sel;
					res_d.last           = (len_sel == 16'd0);
					left_d  = len_sel;
					phase_d = (len_sel == 16'd0) ? PH_HUNT : PH_DATA;
				end
			end
			PH_DATA: begin
				left_d  = left_dec;
				res_vld = 1'b1;
				res_d.kind      = KIND_PAYLOAD;
				res_d.data_byte = rx_byte;
				res_d.last      = (left_dec == 16'd0);
				if (left_dec == 16'd0) phase_d = PH_HUNT;
			end
			PH_SKIP: begin
				if (rx_byte == 8'd0) phase_d = PH_HUNT;
			end
			default: begin
				phase_d = hunt_phase;
				res_vld = hunt_vld;
				res_d.kind      = KIND_DROP;
				res_d.data_byte = rx_byte;
			end
		endcase
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			flag_q    <= '0;
			pf_q      <= '0;
			ps_q      <= '0;
			src_q     <= '0;
			len_low_q <= '0;
			left_q    <= '0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			case (phase_q)
				PH_FLAG: if ((rx_byte & flag_mask_q) != 8'd0) flag_q <= rx_byte;
				PH_PF:   pf_q      <= rx_byte;
				PH_PS:   ps_q      <= rx_byte;
				PH_SRC:  src_q     <= rx_byte;
				PH_LEN0: len_low_q <= rx_byte;
				default: len_low_q <= len_low_q;
			endcase
		end
	end

	// two-entry output buffer: result register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_fire) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
			if (in_fire && res_vld) begin
				if (out_valid_q && !out_fire) skid_valid_q <= 1'b1;
				else out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire && skid_valid_q) out_q <= skid_q;
		if (in_fire && res_vld) begin
			if (out_valid_q && !out_fire) skid_q <= res_d;
			else out_q <= res_d;
		end
	end

	assign kind           = out_q.kind;
	assign group_number   = out_q.group_number;
	assign priority_res   = out_q.priority_res;
	assign source         = out_q.source;
	assign destination    = out_q.destination;
	assign message_type   = out_q.message_type;
	assign payload_length = out_q.payload_length;
	assign data_byte      = out_q.data_byte;
	assign last           = out_q.last;

`include "gateway_binary_frame_deframer_top_macros.svh"

	`GBFD_AST_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q)
	`GBFD_AST_IMPL(a_data_has_bytes, phase_q == PH_DATA, left_q != 16'd0)
	`GBFD_AST_IMPL(a_drop_not_last, out_valid_q && out_q.kind == KIND_DROP, !out_q.last)
	`GBFD_AST_NEXT(a_result_lands, in_fire && res_vld, out_valid_q)

endmodule

### test/tb.sv
// testbench for the gateway binary frame deframer: table-driven and random byte streams
`timescale 1ns / 100ps

module tb;
	import gbfd_pkg::*;

	typedef enum logic [3:0] {
		FR_HUNT, FR_FLAG, FR_PF, FR_PS, FR_SRC, FR_LEN0, FR_LEN1, FR_DATA, FR_SKIP
	} fr_phase_t;

	typedef enum logic [1:0] {ROW_QUIET, ROW_DROP, ROW_PRED} row_mode_t;

	typedef struct packed {
		logic [7:0] b;
		row_mode_t  mode;
	} dir_row_t;

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	logic            in_ready;
	logic [7:0]      rx_byte   = 8'h00;
	logic            out_valid;
	logic            out_ready = 1'b0;
	kind_t           kind;
	logic [16:0]     group_number;
	logic [2:0]      priority_res;
	logic [7:0]      source;
	logic [7:0]      destination;
	logic [1:0]      message_type;
	logic [15:0]     payload_length;
	logic [7:0]      data_byte;
	logic            last;
	logic            cfg_we    = 1'b0;
	logic [1:0]      cfg_index = 2'd0;
	logic [7:0]      cfg_data  = 8'h00;

	gateway_binary_frame_deframer_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .group_number(group_number), .priority_res(priority_res),
		.source(source), .destination(destination), .message_type(message_type),
		.payload_length(payload_length), .data_byte(data_byte), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the registers and the frame state
	logic [7:0]  cfg_sync  = SYNC_RESET;
	logic [7:0]  cfg_mask  = FLAG_RESET;
	logic [7:0]  cfg_video = VIDEO_RESET;
	logic [7:0]  cfg_text  = TEXT_RESET;
	fr_phase_t   fr_phase  = FR_HUNT;
	logic [7:0]  fr_flag   = 8'h00;
	logic [7:0]  fr_pf     = 8'h00;
	logic [7:0]  fr_ps     = 8'h00;
	logic [7:0]  fr_src    = 8'h00;
	logic [7:0]  fr_len_lo = 8'h00;
	logic [15:0] fr_left   = 16'h0000;

	res_t expected_deframed [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int n_errors      = 0;
	int n_bytes       = 0;
	int phase_items   = 0;
	int n_headers     = 0;
	int n_payload     = 0;
	int n_drops       = 0;

	// reset settings: skip, markers, drops, lone nul, missing flag bit, two frames
	dir_row_t dir_rows [0:24] = '{
		'{8'h41, ROW_QUIET}, '{8'hFD, ROW_QUIET}, '{8'h00, ROW_QUIET},
		'{8'h80, ROW_DROP},  '{8'hFF, ROW_DROP},  '{8'h00, ROW_QUIET},
		'{8'hFE, ROW_QUIET}, '{8'h00, ROW_QUIET},
		'{8'hA5, ROW_QUIET}, '{8'h7F, ROW_QUIET}, '{8'h00, ROW_QUIET},
		'{8'hA5, ROW_QUIET}, '{8'hFF, ROW_QUIET}, '{8'hF0, ROW_QUIET},
		'{8'h12, ROW_QUIET}, '{8'hFF, ROW_QUIET}, '{8'h00, ROW_QUIET},
		'{8'h00, ROW_PRED},
		'{8'hA5, ROW_QUIET}, '{8'h80, ROW_QUIET}, '{8'hEF, ROW_QUIET},
		'{8'h00, ROW_QUIET}, '{8'h00, ROW_QUIET}, '{8'h01, ROW_PRED},
		'{8'hFF, ROW_PRED}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("timeout waiting for the deframer");
		$display("== FAIL ==");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		if (n_errors < 40)
			$display("[%0t] mismatch: %s", $time, msg);
		n_errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic bit hunt_byte(input logic [7:0] b, output res_t r);
		r = '0;
		if (b == cfg_sync) begin
			fr_phase = FR_FLAG;
			return 1'b0;
		end
		if (b == cfg_video || b == cfg_text || !b[7]) begin
			fr_phase = (b == 8'h00) ? FR_HUNT : FR_SKIP;
			return 1'b0;
		end
		r.kind = KIND_DROP;
		r.data_byte = b;
		return 1'b1;
	endfunction

	function automatic bit header_res(input logic [15:0] len, output res_t r);
		logic [16:0] gn;
		logic [7:0]  dst;
		gn = {fr_flag[0], fr_pf, 8'h00};
		dst = fr_ps;
		// pdu2 range carries the ps byte in the group number and goes to everyone
		if (fr_pf >= PF_PDU2_MIN) begin
			gn[7:0] = fr_ps;
			dst = BROADCAST;
		end
		r = '0;
		r.kind = KIND_HEADER;
		r.group_number = gn;
		r.priority_res = fr_flag[6:4];
		r.source = fr_src;
		r.destination = dst;
		r.message_type = fr_flag[2:1];
		r.payload_length = len;
		r.last = (len == 16'h0000);
		fr_left = len;
		fr_phase = (len == 16'h0000) ? FR_HUNT : FR_DATA;
		return 1'b1;
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
		r = '0;
		case (fr_phase)
			FR_FLAG: begin
				if ((b & cfg_mask) == 8'h00) begin
					// flag bit missing: this byte is looked at again as a new start
					fr_phase = FR_HUNT;
					return hunt_byte(b, r);
				end
				fr_flag = b;
				fr_phase = FR_PF;
				return 1'b0;
			end
			FR_PF: begin
				fr_pf = b;
				fr_phase = FR_PS;
				return 1'b0;
			end
			FR_PS: begin
				fr_ps = b;
				fr_phase = FR_SRC;
				return 1'b0;
			end
			FR_SRC: begin
				fr_src = b;
				fr_phase = FR_LEN0;
				return 1'b0;
			end
			FR_LEN0: begin
				fr_len_lo = b;
				if (fr_flag[2:1] == TYPE_LONGLEN) begin
					fr_phase = FR_LEN1;
					return 1'b0;
				end
				return header_res({8'h00, b}, r);
			end
			FR_LEN1: return header_res({b, fr_len_lo}, r);
			FR_DATA: begin
				fr_left = fr_left - 16'd1;
				r.kind = KIND_PAYLOAD;
				r.data_byte = b;
				r.last = (fr_left == 16'h0000);
				if (fr_left == 16'h0000)
					fr_phase = FR_HUNT;
				return 1'b1;
			end
			FR_SKIP: begin
				if (b == 8'h00)
					fr_phase = FR_HUNT;
				return 1'b0;
			end
			default: begin
				fr_phase = FR_HUNT;
				return hunt_byte(b, r);
			end
		endcase
	endfunction

	// offer one byte, wait for it to be taken, then predict what it causes
	task automatic push_byte(input logic [7:0] b, input bit typed, input bit typed_has,
			input res_t typed_res);
		res_t      r;
		bit        has;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		has = deframe_byte(b, r);
		if (typed) begin
			has = typed_has;
			r = typed_res;
		end
		if (has)
			expected_deframed.push_back(r);
		n_bytes++;
		phase_items++;
	endtask

	task automatic send(input logic [7:0] b);
		push_byte(b, 1'b0, 1'b0, '0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_deframed.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_SYNC_VALUE:   cfg_sync = val;
			REG_FLAG_MASK:    cfg_mask = val;
			REG_VIDEO_MARKER: cfg_video = val;
			REG_TEXT_MARKER:  cfg_text = val;
			default: ;
		endcase
	endtask

	task automatic load_registers(input logic [7:0] s, input logic [7:0] m,
			input logic [7:0] v, input logic [7:0] t);
		write_reg(REG_SYNC_VALUE, s);
		write_reg(REG_FLAG_MASK, m);
		write_reg(REG_VIDEO_MARKER, v);
		write_reg(REG_TEXT_MARKER, t);
		cfg_we <= 1'b0;
	endtask

	// feed bytes until the frame state is back to hunting
	task automatic bring_to_hunt();
		while (fr_phase != FR_HUNT) begin
			case (fr_phase)
				FR_FLAG: begin
					if (cfg_mask != 8'h00)
						send(cfg_mask);
					else
						send(~cfg_sync);
				end
				FR_DATA: send(8'($urandom));
				default: send(8'h00);
			endcase
		end
	endtask

	task automatic settle();
		bring_to_hunt();
		drain();
		// a byte with no result may still be in flight
		repeat (6) @(posedge clk);
	endtask

	task automatic send_frame(input bit force_long, input logic [15:0] len);
		logic [7:0] flag;
		logic [7:0] pf;
		logic [7:0] low;
		low = cfg_mask & (~cfg_mask + 8'd1);
		flag = 8'($urandom);
		if ((flag & cfg_mask) == 8'h00)
			flag = flag | low;
		if (force_long)
			flag[2:1] = TYPE_LONGLEN;
		pf = ($urandom_range(3) == 0) ? (PF_PDU2_MIN | 8'($urandom_range(15))) : 8'($urandom);
		send(cfg_sync);
		send(flag);
		send(pf);
		send(8'($urandom));
		send(8'($urandom));
		send(len[7:0]);
		if (flag[2:1] == TYPE_LONGLEN)
			send(len[15:8]);
		else
			len[15:8] = 8'h00;
		repeat (len) send(8'($urandom));
	endtask

	task automatic gen_packet();
		int         sel;
		int         n;
		logic [15:0] len;
		logic [7:0] flag;
		logic [7:0] low;
		sel = $urandom_range(99);
		if (sel < 65) begin
			n = $urandom_range(99);
			if (n < 8)
				len = 16'd0;
			else if (n < 90)
				len = 16'($urandom_range(16, 1));
			else if (n < 97)
				len = 16'($urandom_range(255, 17));
			else
				len = 16'($urandom_range(511, 256));
			send_frame(1'b0, len);
		end else if (sel < 77) begin
			// text or video message up to its nul
			send($urandom_range(1) ? cfg_video : cfg_text);
			repeat ($urandom_range(6)) send(8'($urandom_range(255, 1)));
			send(8'h00);
		end else if (sel < 90) begin
			repeat ($urandom_range(3, 1)) send(8'($urandom));
		end else if ($urandom_range(1)) begin
			send(cfg_sync);
			send(8'($urandom) & ~cfg_mask);
		end else begin
			// truncated short-length header, the next packet fills the rest
			low = cfg_mask & (~cfg_mask + 8'd1);
			flag = 8'($urandom) | low;
			if (flag[2:1] == TYPE_LONGLEN) begin
				if (low == 8'h02)
					flag[2] = 1'b0;
				else
					flag[1] = 1'b0;
			end
			send(cfg_sync);
			send(flag);
			repeat ($urandom_range(3)) send(8'($urandom));
		end
	endtask

	task automatic run_random(input int n);
		phase_items = 0;
		while (phase_items < n)
			gen_packet();
	endtask

	// receiver: check each result taken and stall at random
	initial begin
		res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_deframed.size() == 0) begin
					note_mismatch($sformatf("result with nothing expected: kind %0d byte %02h",
						kind, data_byte));
				end else begin
					want = expected_deframed.pop_front();
					check_field("kind", 32'(kind), 32'(want.kind));
					check_field("group_number", 32'(group_number), 32'(want.group_number));
					check_field("priority_res", 32'(priority_res), 32'(want.priority_res));
					check_field("source", 32'(source), 32'(want.source));
					check_field("destination", 32'(destination), 32'(want.destination));
					check_field("message_type", 32'(message_type), 32'(want.message_type));
					check_field("payload_length", 32'(payload_length),
						32'(want.payload_length));
					check_field("data_byte", 32'(data_byte), 32'(want.data_byte));
					check_field("last", 32'(last), 32'(want.last));
					case (want.kind)
						KIND_HEADER:  n_headers++;
						KIND_PAYLOAD: n_payload++;
						default:      n_drops++;
					endcase
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		res_t r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 64;
		foreach (dir_rows[i]) begin
			case (dir_rows[i].mode)
				ROW_QUIET: push_byte(dir_rows[i].b, 1'b1, 1'b0, '0);
				ROW_DROP: begin
					r = '0;
					r.kind = KIND_DROP;
					r.data_byte = dir_rows[i].b;
					push_byte(dir_rows[i].b, 1'b1, 1'b1, r);
				end
				default: push_byte(dir_rows[i].b, 1'b0, 1'b0, '0);
			endcase
		end
		run_random(80);
		drain();
		run_random(80);

		settle();
		load_registers(8'h00, 8'hFF, 8'hFF, 8'h80);
		run_random(150);

		send_idle_pct = 64;
		recv_idle_pct = 15;
		settle();
		// zero mask never accepts a frame, markers equal to nul
		load_registers(8'hFF, 8'h00, 8'h00, 8'h00);
		run_random(110);

		settle();
		load_registers(8'($urandom), 8'($urandom_range(255, 1)), 8'($urandom), 8'($urandom));
		run_random(150);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		settle();
		load_registers(SYNC_RESET, 8'h01, VIDEO_RESET, TEXT_RESET);
		run_random(150);
		bring_to_hunt();
		send_frame(1'b1, 16'h0102);

		drain();
		repeat (20) @(posedge clk);
		if (expected_deframed.size() != 0)
			note_mismatch($sformatf("%0d expected results never came", expected_deframed.size()));

		$display("sent %0d bytes; checked %0d headers, %0d payload bytes, %0d dropped bytes",
			n_bytes, n_headers, n_payload, n_drops);
		$display("five register settings incl. zero mask and nul markers, mixed stalls, 16-bit length frame");
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/gbfd_pkg.sv
hw/rtl/gateway_binary_frame_deframer_top.sv
test/tb.sv
